// ===== rtl/core/baro_pkg.sv =====
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SENS_COEF     = 3'd0;
    localparam logic [2:0] REG_OFF_COEF      = 3'd1;
    localparam logic [2:0] REG_SENS_TC_COEF  = 3'd2;
    localparam logic [2:0] REG_OFF_TC_COEF   = 3'd3;
    localparam logic [2:0] REG_REF_TEMP_COEF = 3'd4;
    localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

    localparam logic signed [18:0] TEMP_BASE     = 19'sd2000;
    localparam logic signed [18:0] COLD_SPLIT    = 19'sd3500;   // 2000 - (-1500)
    localparam logic signed [17:0] TEMP_OUT_MIN  = -18'sd131072;
    localparam logic signed [17:0] TEMP_OUT_MAX  = 18'sd131071;
    localparam logic [16:0]        PRESS_OUT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [15:0] c1;   // pressure sensitivity
        logic [15:0] c2;   // pressure offset
        logic [15:0] c3;   // temp coefficient of sensitivity
        logic [15:0] c4;   // temp coefficient of offset
        logic [15:0] c5;   // reference temperature
        logic [15:0] c6;   // temp coefficient of temperature
    } cfg_t;

    // First-order terms
    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [34:0] off;
        logic signed [33:0] sens;
        logic signed [17:0] tdelta;   // temp - 2000
        logic signed [18:0] tplus;    // temp + 1500
        logic               cold;     // temp below 2000
        logic               frigid;   // temp below -1500
        logic [23:0]        d1;
    } front_t;

    // Corrected offset and sensitivity
    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [39:0] off_c;
        logic signed [38:0] sens_c;
        logic [23:0]        d1;
    } corr_t;

    typedef struct packed {
        logic signed [17:0] temp_centi;
        logic [16:0]        pressure_pa;
        logic               pressure_sat;
    } res_t;

endpackage

// ===== rtl/core/baro_pressure_temp_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Second-order compensation of raw barometric pressure and temperature.
// ----------------------------------------------------------------------------
// Each input item carries one raw pressure and one raw temperature conversion;
// each produces exactly one result item with temperature in 0.01 C, pressure
// in Pa clamped to 0..131071 and a flag set when that clamp was taken. The
// datapath is an eight-stage pipeline that takes one new item per clock unless
// the result side stalls; it takes new items while earlier ones are still in
// flight. The stage boundaries follow the chain of multipliers
// (coefficient products, correction squares, the split 24x39 pressure
// product), each followed by a register. The whole pipeline advances together
// whenever the output register is empty or being drained, so a stall on the
// result side holds every stage in place and nothing is lost or repeated.
// Calibration words are written through the plain write port and take effect
// for items accepted afterwards; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] pressure_raw, [47:24] temperature_raw
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [17:0] temperature_centi, [34:18] pressure_pa,
                                        // [35] pressure_saturated, [39:36] zero
);
    import baro_pkg::*;

    cfg_t    cfg_reg;
    logic    en;
    logic    front_valid, corr_valid, res_valid;
    front_t  front_data;
    corr_t   corr_data;
    res_t    res_data;

    // Calibration registers; writes to unused indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SENS_COEF:     cfg_reg.c1 <= cfg_wdata;
                REG_OFF_COEF:      cfg_reg.c2 <= cfg_wdata;
                REG_SENS_TC_COEF:  cfg_reg.c3 <= cfg_wdata;
                REG_OFF_TC_COEF:   cfg_reg.c4 <= cfg_wdata;
                REG_REF_TEMP_COEF: cfg_reg.c5 <= cfg_wdata;
                REG_TEMP_SLOPE:    cfg_reg.c6 <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Advance all stages when the output register is free or being taken
    assign en            = !res_valid || m_axis_tready;
    assign s_axis_tready = en;

    baro_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .d1        (s_axis_tdata[23:0]),
        .d2        (s_axis_tdata[47:24]),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    baro_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_data  (corr_data)
    );

    baro_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (corr_valid),
        .in_data   (corr_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {4'b0000, res_data.pressure_sat, res_data.pressure_pa,
                            res_data.temp_centi};

endmodule

// ===== rtl/core/baro_front.sv =====
// ----------------------------------------------------------------------------
// baro_front
// Stages 1-3: temperature difference, coefficient products, first-order terms.
// ----------------------------------------------------------------------------
module baro_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  baro_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  logic [23:0]       d1,
    input  logic [23:0]       d2,
    output logic              out_valid,
    output baro_pkg::front_t  out_data
);
    import baro_pkg::*;

    logic                v1_reg, v2_reg, v3_reg;
    logic signed [24:0]  dt_next, dt_reg;
    logic [23:0]         d1_s1_reg, d1_s2_reg;
    logic signed [41:0]  p6_next, p4_next, p3_next;
    logic signed [41:0]  p6_reg, p4_reg, p3_reg;
    front_t              front_next, front_reg;

    assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, cfg.c5, 8'h00});

    assign p6_next = 42'(dt_reg) * 42'($signed({1'b0, cfg.c6}));
    assign p4_next = 42'(dt_reg) * 42'($signed({1'b0, cfg.c4}));
    assign p3_next = 42'(dt_reg) * 42'($signed({1'b0, cfg.c3}));

    always_comb
    begin
        front_next.tdelta = p6_reg[40:23];
        front_next.temp   = $signed({p6_reg[40], p6_reg[40:23]}) + TEMP_BASE;
        front_next.tplus  = $signed({p6_reg[40], p6_reg[40:23]}) + COLD_SPLIT;
        front_next.off    = $signed({3'b000, cfg.c2, 16'h0000}) + $signed(p4_reg[41:7]);
        front_next.sens   = $signed({3'b000, cfg.c1, 15'h0000}) + $signed(p3_reg[41:8]);
        front_next.cold   = p6_reg[40];
        front_next.frigid = front_next.tplus[18];
        front_next.d1     = d1_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= d1;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
            d1_s2_reg <= d1_s1_reg;
            front_reg <= front_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = front_reg;

endmodule

// ===== rtl/core/baro_corr.sv =====
// ----------------------------------------------------------------------------
// baro_corr
// Stages 4-5: second-order squares and corrected offset and sensitivity.
// ----------------------------------------------------------------------------
module baro_corr (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  baro_pkg::front_t  in_data,
    output logic              out_valid,
    output baro_pkg::corr_t   out_data
);
    import baro_pkg::*;

    logic                v4_reg, v5_reg;
    logic signed [35:0]  dsq_full;
    logic signed [37:0]  esq_full;
    logic [33:0]         dsq_next, esq_next, dsq_reg, esq_reg;
    logic signed [18:0]  temp4_reg;
    logic signed [34:0]  off4_reg;
    logic signed [33:0]  sens4_reg;
    logic [23:0]         d1_4_reg;
    logic [36:0]         five_d, seven_e;
    logic [37:0]         eleven_e;
    logic [37:0]         off2;
    logic [36:0]         sens2;
    corr_t               corr_next, corr_reg;

    // Square the distances; drop them where the correction does not apply
    assign dsq_full = in_data.tdelta * in_data.tdelta;
    assign esq_full = in_data.tplus * in_data.tplus;
    assign dsq_next = in_data.cold   ? dsq_full[33:0] : 34'd0;
    assign esq_next = in_data.frigid ? esq_full[33:0] : 34'd0;

    always_comb
    begin
        five_d   = {3'b000, dsq_reg} + {1'b0, dsq_reg, 2'b00};
        seven_e  = {esq_reg, 3'b000} - {3'b000, esq_reg};
        eleven_e = {1'b0, esq_reg, 3'b000} + {3'b000, esq_reg, 1'b0} + {4'b0000, esq_reg};
        off2     = {2'b00, five_d[36:1]} + {1'b0, seven_e};
        sens2    = {2'b00, five_d[36:2]} + eleven_e[37:1];
        corr_next.temp   = temp4_reg;
        corr_next.off_c  = 40'(off4_reg) - $signed({2'b00, off2});
        corr_next.sens_c = 39'(sens4_reg) - $signed({2'b00, sens2});
        corr_next.d1     = d1_4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_reg   <= dsq_next;
            esq_reg   <= esq_next;
            temp4_reg <= in_data.temp;
            off4_reg  <= in_data.off;
            sens4_reg <= in_data.sens;
            d1_4_reg  <= in_data.d1;
            corr_reg  <= corr_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = corr_reg;

endmodule

// ===== rtl/core/baro_press.sv =====
// ----------------------------------------------------------------------------
// baro_press
// Stages 6-8: split pressure product, final scaling and output clamps.
// ----------------------------------------------------------------------------
module baro_press (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  baro_pkg::corr_t  in_data,
    output logic             out_valid,
    output baro_pkg::res_t   out_data
);
    import baro_pkg::*;

    logic                v6_reg, v7_reg, v8_reg;
    logic [43:0]         lo_next, lo_reg;
    logic signed [43:0]  hi_next, hi_reg;
    logic signed [39:0]  off6_reg;
    logic signed [18:0]  temp6_reg, temp7_reg;
    logic signed [63:0]  full;
    logic signed [42:0]  q_next, q_reg;
    logic signed [27:0]  p;
    res_t                res_next, res_reg;

    // D1 times sensitivity as two partial products on a 20-bit split
    assign lo_next = {20'd0, in_data.d1} * {24'd0, in_data.sens_c[19:0]};
    assign hi_next = 44'($signed({1'b0, in_data.d1})) * 44'($signed(in_data.sens_c[38:20]));

    assign full   = (64'(hi_reg) <<< 20) + $signed({20'd0, lo_reg});
    assign q_next = $signed(full[63:21]) - 43'(off6_reg);

    always_comb
    begin
        p = q_reg[42:15];
        res_next.pressure_sat = p[27] | (|p[26:17]);
        if (p[27])
            res_next.pressure_pa = 17'd0;
        else if (|p[26:17])
            res_next.pressure_pa = PRESS_OUT_MAX;
        else
            res_next.pressure_pa = p[16:0];
        if (temp7_reg[18] == temp7_reg[17])
            res_next.temp_centi = temp7_reg[17:0];
        else if (temp7_reg[18])
            res_next.temp_centi = TEMP_OUT_MIN;
        else
            res_next.temp_centi = TEMP_OUT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= in_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            off6_reg  <= in_data.off_c;
            temp6_reg <= in_data.temp;
            q_reg     <= q_next;
            temp7_reg <= temp6_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = v8_reg;
    assign out_data  = res_reg;

endmodule

// ===== tb/baro_pressure_temp_compensation_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit_tb
// Self-checking bench for the barometric compensation pipeline. It loads sets
// of calibration words through the write port and streams raw pressure and
// temperature pairs into the block. Each result is checked, field by field,
// against a 64-bit integer prediction of the second-order compensation.
// Directed items come first, then long random runs under random source gaps
// and sink stalls, and one long sink hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_unit_tb;

    import baro_pkg::*;

    // Register indexes past the last calibration word; writes there must be dropped
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    // Compensation thresholds and output ranges, in the units of the result fields
    localparam longint COLD_KNEE   = 2000;      // 20.00 C
    localparam longint FRIGID_KNEE = -1500;     // -15.00 C
    localparam longint TEMP_LO     = -131072;
    localparam longint TEMP_HI     = 131071;
    localparam longint PRESS_HI    = 131071;
    localparam int     RAW_MAX     = 16777215;

    // Eight pipeline stages; DRAIN_CYCLES lets the block settle after draining
    localparam int DRAIN_CYCLES    = 16;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 130;
    localparam int FLOOD_ITEMS     = 60;
    localparam int REPORT_LIMIT    = 10;

    // Typical factory calibration of this sensor family
    localparam cfg_t NOMINAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                     c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
    localparam cfg_t FULL_CAL    = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                                     c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF};
    // Reference temperature at zero: the hottest raw reading overflows the output
    localparam cfg_t HOT_CAL     = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                                     c4: 16'hFFFF, c5: 16'h0000, c6: 16'hFFFF};

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [2:0]  cfg_index      = REG_SENS_COEF;
    logic [15:0] cfg_wdata      = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata   = '0;   // [23:0] pressure_raw, [47:24] temperature_raw
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [39:0] m_axis_tdata;          // [17:0] temperature_centi, [34:18] pressure_pa,
                                        // [35] pressure_saturated, [39:36] zero

    // Calibration words as the block should currently hold them
    cfg_t cal_words = '0;
    // Compensated readings still owed by the block, oldest first
    res_t pending_readings[$];
    int   mismatch_count = 0;

    // Traffic shaping, switched per test
    bit src_gaps_on       = 1'b0;
    bit sink_stalls_on    = 1'b0;
    bit hold_results_req  = 1'b0;   // set by a test, cleared by the sink after the hold

    baro_pressure_temp_compensation_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: second-order compensation, exact in 64-bit signed integers.
    // Every right shift of a signed longint is arithmetic, so each division by
    // a power of two rounds toward minus infinity as the scheme requires.
    // ------------------------------------------------------------------------
    function automatic res_t compensate_reading(input logic [23:0] d1,
                                                input logic [23:0] d2);
        longint dt, temp, off, sens, off2, sens2, sq, p;
        res_t   r;
        dt   = longint'(d2) - longint'(cal_words.c5) * 256;
        temp = COLD_KNEE + ((dt * longint'(cal_words.c6)) >>> 23);
        off  = longint'(cal_words.c2) * 65536 + ((dt * longint'(cal_words.c4)) >>> 7);
        sens = longint'(cal_words.c1) * 32768 + ((dt * longint'(cal_words.c3)) >>> 8);
        off2  = 0;
        sens2 = 0;
        // Below 20 C subtract the quadratic correction; below -15 C grow it further.
        // The corrections always see the unclamped temperature.
        if (temp < COLD_KNEE)
        begin
            sq    = (temp - COLD_KNEE) * (temp - COLD_KNEE);
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < FRIGID_KNEE)
            begin
                sq    = (temp - FRIGID_KNEE) * (temp - FRIGID_KNEE);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        p = (((longint'(d1) * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
        r.pressure_sat = (p < 0) || (p > PRESS_HI);
        if (p < 0)
            p = 0;
        else if (p > PRESS_HI)
            p = PRESS_HI;
        // Temperature is clamped silently: no flag for it
        if (temp < TEMP_LO)
            temp = TEMP_LO;
        else if (temp > TEMP_HI)
            temp = TEMP_HI;
        r.temp_centi  = 18'(temp);
        r.pressure_pa = 17'(p);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Source side: offer one item, hold it until taken, record its reading.
    // tvalid stays high across back-to-back items and drops only for a gap.
    // ------------------------------------------------------------------------
    task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d2, d1};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_readings.push_back(compensate_reading(d1, d2));
    endtask

    // Drop valid, let every owed reading come back, then let the pipeline settle
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers the write enable after its last write
    task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Load all six calibration words while the pipeline is empty
    task automatic program_coefs(input cfg_t c);
        wait_drain();
        put_reg(REG_SENS_COEF,     c.c1);
        put_reg(REG_OFF_COEF,      c.c2);
        put_reg(REG_SENS_TC_COEF,  c.c3);
        put_reg(REG_OFF_TC_COEF,   c.c4);
        put_reg(REG_REF_TEMP_COEF, c.c5);
        put_reg(REG_TEMP_SLOPE,    c.c6);
        cfg_we    <= 1'b0;
        cal_words  = c;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All words reset to zero: pressure reads 0 unsaturated, temperature 20.00 C
    task automatic test_reset_state();
        send_pair(24'd9085466, 24'd8569150);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Writes to indexes past the last word must not disturb the calibration
    task automatic test_unused_index();
        program_coefs(NOMINAL_CAL);
        put_reg(REG_UNUSED_LO, 16'hFFFF);
        put_reg(REG_UNUSED_HI, 16'h0000);
        cfg_we <= 1'b0;
        send_pair(24'd9085466, 24'd8569150);
        send_pair(24'd7000000, 24'd8000000);
    endtask

    // Walk the temperature across the cold and frigid thresholds
    task automatic test_temperature_bands();
        logic [23:0] knee;
        knee = {NOMINAL_CAL.c5, 8'h00};     // dT of zero: exactly 20.00 C
        send_pair(24'd9085466, knee);
        send_pair(24'd9085466, knee - 24'd1);           // first step below the knee
        send_pair(24'd9085466, knee - 24'd1000000);     // cold, above -15 C
        send_pair(24'd9085466, knee - 24'd2000000);     // frigid
        send_pair(24'd9085466, 24'd0);                  // coldest the raw field allows
        send_pair(24'd9085466, 24'hFFFFFF);             // hottest
    endtask

    // Extremes and alternating bit patterns of both raw fields
    task automatic test_field_extremes();
        send_pair(24'd0, 24'd0);
        send_pair(24'hFFFFFF, 24'd0);
        send_pair(24'hAAAAAA, 24'h555555);
        send_pair(24'h555555, 24'hAAAAAA);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Full-scale words: pressure clamps both ways; a zero reference temperature
    // then drives the temperature past its upper limit
    task automatic test_saturation();
        program_coefs(FULL_CAL);
        send_pair(24'd0, 24'hFFFFFF);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'd0, 24'd0);
        send_pair(24'hFFFFFF, {FULL_CAL.c5, 8'h00});
        program_coefs(HOT_CAL);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'd0, 24'hFFFFFF);
        program_coefs('0);
        send_pair(24'h123456, 24'hFEDCBA);
    endtask

    // Random calibrations, each followed by a run of random conversions
    task automatic test_random_calibrations();
        logic [5:0][15:0] words;
        logic [5:0][15:0] base;
        logic [23:0]      d1, d2;
        int               t;
        base = NOMINAL_CAL;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // Every word picks zero, full scale, anything, or near nominal
            for (int k = 0; k < 6; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       words[k] = 16'h0000;
                    1:       words[k] = 16'hFFFF;
                    2:       words[k] = 16'($urandom);
                    default: words[k] = 16'(int'(base[k]) + $urandom_range(0, 8000) - 4000);
                endcase
            end
            if (ph == 0)
                words = base;
            program_coefs(cfg_t'(words));
            // Rotate traffic: quiet both sides, busy both sides, source gaps only
            src_gaps_on    = (ph % 3) != 0;
            sink_stalls_on = (ph % 3) == 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Keep most temperatures near the reference, leaning cold
                if ($urandom_range(0, 3) == 0)
                    d2 = 24'($urandom);
                else
                begin
                    t = int'(cal_words.c5) * 256 + int'($urandom_range(0, 6000000)) - 4000000;
                    if (t < 0)
                        t = 0;
                    else if (t > RAW_MAX)
                        t = RAW_MAX;
                    d2 = 24'(t);
                end
                if ($urandom_range(0, 1) == 0)
                    d1 = 24'($urandom);
                else
                    d1 = 24'($urandom_range(6000000, 10000000));
                send_pair(d1, d2);
            end
        end
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
    endtask

    // Hold the sink off for a long stretch while the source keeps offering items
    task automatic test_backpressure();
        program_coefs(NOMINAL_CAL);
        hold_results_req = 1'b1;
        for (int n = 0; n < FLOOD_ITEMS; n++)
            send_pair(24'($urandom_range(6000000, 10000000)), 24'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_unused_index();
        test_temperature_bands();
        test_field_extremes();
        test_saturation();
        test_random_calibrations();
        test_backpressure();
        wait_drain();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink side: always ready, random stalls, or one long hold on request.
    // The hold is counted here so the source keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_results_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results_req = 1'b0;
            end
            else if (sink_stalls_on)
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare every accepted result with the oldest owed reading
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.temp_centi   = m_axis_tdata[17:0];
            got.pressure_pa  = m_axis_tdata[34:18];
            got.pressure_sat = m_axis_tdata[35];
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result item, tdata %h", $realtime, m_axis_tdata);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.temp_centi !== want.temp_centi
                    || got.pressure_pa !== want.pressure_pa
                    || got.pressure_sat !== want.pressure_sat
                    || m_axis_tdata[39:36] !== 4'h0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: mismatch temperature_centi exp %0d got %0d, ",
                                  "pressure_pa exp %0d got %0d, saturated exp %b got %b, ",
                                  "pad %h"},
                                 $realtime, want.temp_centi, got.temp_centi,
                                 want.pressure_pa, got.pressure_pa,
                                 want.pressure_sat, got.pressure_sat, m_axis_tdata[39:36]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run once nothing has moved on either side for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
